// ----- rtl/core/h3d_pkg.sv -----
// shared types, constants and the crc step for the hdlc type-3 deframer
`default_nettype none

package h3d_pkg;

  // frame bytes and crc constants
  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  LLC_E6    = 8'hE6;
  localparam logic [7:0]  LLC_E7    = 8'hE7;
  localparam logic [7:0]  LLC_ZERO  = 8'h00;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_GOOD  = 16'hF0B8;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [10:0] MIN_LEN   = 11'd9;
  localparam logic [2:0]  ADDR_MAX  = 3'd4;
  localparam logic [11:0] SHORT_POS = 12'd3;

  // width of the byte position counter (length plus the closing byte)
  localparam int POS_W = 12;

  // buffer status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_FLAG = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_HEADER   = 3'd4;
  localparam logic [2:0] ST_HCS      = 3'd5;
  localparam logic [2:0] ST_FCS      = 3'd6;
  localparam logic [2:0] ST_NO_PAY   = 3'd7;

  // parser phases
  typedef enum logic [10:0] {
    PH_FLAG  = 11'b000_0000_0001,
    PH_FMT1  = 11'b000_0000_0010,
    PH_FMT2  = 11'b000_0000_0100,
    PH_SHORT = 11'b000_0000_1000,
    PH_DST   = 11'b000_0001_0000,
    PH_SRC   = 11'b000_0010_0000,
    PH_CTRL  = 11'b000_0100_0000,
    PH_HCS1  = 11'b000_1000_0000,
    PH_HCS2  = 11'b001_0000_0000,
    PH_DATA  = 11'b010_0000_0000,
    PH_DRAIN = 11'b100_0000_0000
  } phase_t;

  // results caused by one input beat
  typedef struct packed {
    logic [1:0]      n;
    logic            is_stat;
    logic [2:0][7:0] bytes;
    logic [2:0]      status;
    logic [15:0]     count;
  } grp_t;

  // one byte through the reflected x.25 crc
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/h3d_parse.sv -----
// frame parser: phase tracking, crc checks, llc strip and payload counting
`default_nettype none

module h3d_parse #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic          cfg_wr_data,
  input  wire logic          en,
  input  wire logic [7:0]    b,
  input  wire logic          eob,
  output h3d_pkg::grp_t      grp
);
  import h3d_pkg::*;

  phase_t                  ph_r, ph_nxt;
  logic [10:0]             flen_r, flen_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [2:0]              hend_r, hend_nxt;
  logic                    seg_r, seg_nxt;
  logic                    first_r, first_nxt;
  logic [15:0]             crc_r, crc_nxt;
  logic [1:0][7:0]         hold_r, hold_nxt;
  logic [1:0]              held_r, held_nxt;
  logic [COUNT_BITS-1:0]   tot_r, tot_nxt;
  logic [2:0]              err_r, err_nxt;
  logic                    skip_r;

  logic                    done;
  logic [2:0]              hinc;
  logic [1:0]              res_n;
  logic [2:0][7:0]         res_byte;
  logic [POS_W:0]          pos_p1, pos_p2;
  logic [POS_W:0]          flen_x;
  logic                    crc_bad;
  logic [2:0]              st;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // next state and the results of this beat
  always_comb begin
    ph_nxt    = ph_r;
    flen_nxt  = flen_r;
    pos_nxt   = pos_r;
    hend_nxt  = hend_r;
    seg_nxt   = seg_r;
    first_nxt = first_r;
    crc_nxt   = crc_r;
    hold_nxt  = hold_r;
    held_nxt  = held_r;
    tot_nxt   = tot_r;
    err_nxt   = err_r;
    done      = 1'b0;
    hinc      = hend_r + 3'd1;
    res_n     = 2'd0;
    res_byte  = '0;
    pos_p1    = {1'b0, pos_r} + {{POS_W{1'b0}}, 1'b1};
    pos_p2    = {1'b0, pos_r} + {{(POS_W-1){1'b0}}, 2'd2};
    flen_x    = {{(POS_W+1-11){1'b0}}, flen_r};
    crc_bad   = 1'b0;
    st        = ST_OK;

    unique case (ph_r) inside
      PH_DRAIN: begin
      end
      PH_FLAG: begin
        if (b != FLAG_BYTE) begin
          err_nxt = ST_BAD_FLAG;
          ph_nxt  = PH_DRAIN;
        end else begin
          crc_nxt = CRC_INIT;
          ph_nxt  = PH_FMT1;
        end
      end
      PH_FMT1: begin
        crc_nxt  = crc_step(crc_r, b);
        seg_nxt  = b[3];
        flen_nxt = {b[2:0], 8'h00};
        ph_nxt   = PH_FMT2;
      end
      PH_FMT2: begin
        crc_nxt  = crc_step(crc_r, b);
        flen_nxt = {flen_r[10:8], b};
        hend_nxt = 3'd0;
        ph_nxt   = (flen_nxt < MIN_LEN) ? PH_SHORT : PH_DST;
      end
      PH_SHORT: begin
        // wait for four frame bytes and the whole short frame
        if (pos_r >= SHORT_POS && {1'b0, pos_r} >= flen_x + 13'd1) begin
          err_nxt = ST_SHORT;
          ph_nxt  = PH_DRAIN;
        end
      end
      PH_DST, PH_SRC, PH_CTRL, PH_HCS1, PH_HCS2, PH_DATA: begin
        if ({1'b0, pos_r} <= flen_x) begin
          crc_nxt = crc_step(crc_r, b);
          crc_bad = !skip_r && (crc_nxt != CRC_GOOD);
          if (err_r == ST_OK) begin
            unique case (ph_r) inside
              PH_DST, PH_SRC: begin
                hend_nxt = hinc;
                if (b[0]) begin
                  ph_nxt   = (ph_r == PH_DST) ? PH_SRC : PH_CTRL;
                  hend_nxt = 3'd0;
                end else if (hinc >= ADDR_MAX) begin
                  err_nxt = ST_HEADER;
                end
              end
              PH_CTRL: ph_nxt = PH_HCS1;
              PH_HCS1: ph_nxt = PH_HCS2;
              PH_HCS2: begin
                if (crc_bad) begin
                  err_nxt = ST_HCS;
                end else begin
                  ph_nxt   = PH_DATA;
                  held_nxt = 2'd0;
                end
              end
              default: begin
                if (pos_p2 <= flen_x) begin
                  // information byte, llc header held back on the first frame
                  if (!first_r) begin
                    res_byte[res_n] = b;
                    res_n           = res_n + 2'd1;
                    tot_nxt         = sat_inc(tot_nxt);
                  end else begin
                    case (held_r)
                      2'd0: begin
                        if (b == LLC_E6) begin
                          hold_nxt[0] = b;
                          held_nxt    = 2'd1;
                        end else begin
                          res_byte[res_n] = b;
                          res_n           = res_n + 2'd1;
                          tot_nxt         = sat_inc(tot_nxt);
                          first_nxt       = 1'b0;
                        end
                      end
                      2'd1: begin
                        if (b == LLC_E7 || b == LLC_E6) begin
                          hold_nxt[1] = b;
                          held_nxt    = 2'd2;
                        end else begin
                          res_byte[res_n] = hold_r[0];
                          res_n           = res_n + 2'd1;
                          tot_nxt         = sat_inc(tot_nxt);
                          res_byte[res_n] = b;
                          res_n           = res_n + 2'd1;
                          tot_nxt         = sat_inc(tot_nxt);
                          held_nxt        = 2'd0;
                          first_nxt       = 1'b0;
                        end
                      end
                      default: begin
                        if (b != LLC_ZERO) begin
                          res_byte[res_n] = hold_r[0];
                          res_n           = res_n + 2'd1;
                          tot_nxt         = sat_inc(tot_nxt);
                          res_byte[res_n] = hold_r[1];
                          res_n           = res_n + 2'd1;
                          tot_nxt         = sat_inc(tot_nxt);
                          res_byte[res_n] = b;
                          res_n           = res_n + 2'd1;
                          tot_nxt         = sat_inc(tot_nxt);
                        end
                        held_nxt  = 2'd0;
                        first_nxt = 1'b0;
                      end
                    endcase
                  end
                end else if (pos_p1 == flen_x) begin
                  // first fcs byte: release a partial llc header
                  if (held_r >= 2'd1) begin
                    res_byte[res_n] = hold_r[0];
                    res_n           = res_n + 2'd1;
                    tot_nxt         = sat_inc(tot_nxt);
                  end
                  if (held_r >= 2'd2) begin
                    res_byte[res_n] = hold_r[1];
                    res_n           = res_n + 2'd1;
                    tot_nxt         = sat_inc(tot_nxt);
                  end
                  held_nxt = 2'd0;
                end
              end
            endcase
          end
          // last inner byte: header complete and fcs residue
          if ({1'b0, pos_r} == flen_x && err_nxt == ST_OK) begin
            if (ph_nxt != PH_DATA) begin
              err_nxt = ST_HEADER;
            end else if (crc_bad) begin
              err_nxt = ST_FCS;
            end
          end
        end else begin
          // closing byte
          if (err_r != ST_OK) begin
            ph_nxt = PH_DRAIN;
          end else begin
            done      = 1'b1;
            first_nxt = 1'b0;
            held_nxt  = 2'd0;
            ph_nxt    = PH_FLAG;
          end
        end
      end
      default: begin
      end
    endcase

    // byte position within the frame
    if (ph_nxt == PH_FLAG && done) begin
      pos_nxt = '0;
    end else if (ph_nxt != PH_DRAIN) begin
      pos_nxt = pos_p1[POS_W-1:0];
    end

    grp.n       = res_n;
    grp.is_stat = 1'b0;
    grp.bytes   = res_byte;
    grp.status  = ST_OK;
    grp.count   = 16'h0000;

    // end of buffer: status only, then back to the buffer start state
    if (eob) begin
      if (ph_nxt == PH_DRAIN) begin
        st = err_nxt;
      end else if (done) begin
        st = (tot_nxt == '0) ? ST_NO_PAY : ST_OK;
      end else begin
        st = ST_TRUNC;
      end
      grp.n       = 2'd1;
      grp.is_stat = 1'b1;
      grp.bytes   = '0;
      grp.status  = st;
      grp.count   = 16'(tot_nxt);
      ph_nxt      = PH_FLAG;
      flen_nxt    = '0;
      pos_nxt     = '0;
      hend_nxt    = '0;
      seg_nxt     = 1'b0;
      first_nxt   = 1'b1;
      crc_nxt     = CRC_INIT;
      held_nxt    = '0;
      tot_nxt     = '0;
      err_nxt     = ST_OK;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_FLAG;
      flen_r  <= '0;
      pos_r   <= '0;
      hend_r  <= '0;
      seg_r   <= 1'b0;
      first_r <= 1'b1;
      crc_r   <= CRC_INIT;
      held_r  <= '0;
      tot_r   <= '0;
      err_r   <= ST_OK;
      skip_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        skip_r <= cfg_wr_data;
      end
      if (en) begin
        ph_r    <= ph_nxt;
        flen_r  <= flen_nxt;
        pos_r   <= pos_nxt;
        hend_r  <= hend_nxt;
        seg_r   <= seg_nxt;
        first_r <= first_nxt;
        crc_r   <= crc_nxt;
        held_r  <= held_nxt;
        tot_r   <= tot_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // llc holding bytes, always written before use
  always_ff @(posedge clk) begin
    if (en) begin
      hold_r <= hold_nxt;
    end
  end

`ifndef SYNTHESIS
  a_drain_has_err: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_DRAIN) |-> (err_r != ST_OK))
    else $error("drain phase without an error code");
  a_held_first: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r != 2'd0) |-> first_r)
    else $error("llc bytes held outside the first frame");
  a_data_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_DATA) |-> ({1'b0, pos_r} <= flen_x + 13'd1))
    else $error("byte position past the closing byte");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/h3d_outq.sv -----
// result group register and output register, one result beat per cycle while out_stall is low
`default_nettype none

module h3d_outq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire h3d_pkg::grp_t grp_in,
  input  wire logic          grp_load,
  output logic               grp_free,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               out_kind,
  output logic [7:0]         out_payload_byte,
  output logic [2:0]         out_status,
  output logic [15:0]        out_payload_count,
  output logic               out_last
);
  import h3d_pkg::*;

  grp_t       grp_r;
  logic [1:0] idx_r;
  logic       out_vld_r;
  logic       have;
  logic       take;
  logic       last_one;

  // group bookkeeping
  assign have     = (idx_r != grp_r.n);
  assign take     = !out_vld_r || !out_stall;
  assign last_one = ((idx_r + 2'd1) == grp_r.n);
  assign grp_free = !have || (take && last_one);

  // group register and read index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r <= '0;
      idx_r <= 2'd0;
    end else if (grp_load) begin
      grp_r <= grp_in;
      idx_r <= 2'd0;
    end else if (take && have) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (take) begin
      out_vld_r <= have;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (take && have) begin
      out_kind          <= grp_r.is_stat;
      out_payload_byte  <= grp_r.is_stat ? 8'h00 : grp_r.bytes[idx_r];
      out_status        <= grp_r.is_stat ? grp_r.status : ST_OK;
      out_payload_count <= grp_r.is_stat ? grp_r.count : 16'h0000;
      out_last          <= last_one;
    end
  end

  assign out_valid = out_vld_r;

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= grp_r.n)
    else $error("group read index past the group size");
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind) |-> out_last)
    else $error("status beat not marked last");
  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> out_valid)
    else $error("result group broken off before its last beat");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/hdlc_type3_deframer_fcs_check.sv -----
// top level of the hdlc type-3 deframer with hcs and fcs check
//
//   port group  direction  beat
//   in_*        input      one buffer byte and its end-of-buffer marker
//   out_*       output     one payload byte or the final buffer status
//   cfg_*       input      write of skip_crc
//
// A byte is taken each cycle while in_stall is low; its results are registered
// in the group register. It causes up to three result beats, sent from there
// one per cycle while out_stall is low, so such bytes stall the input.
// The byte-wide crc step and the counters sit in one stage.
// Reset is synchronous and needs no clearing pass; stall on the output side
// backs up through the group register and the input register.
`default_nettype none

module hdlc_type3_deframer_fcs_check #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_buffer,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [7:0]       out_payload_byte,
  output logic [2:0]       out_status,
  output logic [15:0]      out_payload_count,
  output logic             out_last,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data
);
  import h3d_pkg::*;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_eob_r;
  logic       grp_free;
  logic       grp_load;
  logic       in_acc;
  grp_t       grp;

  // input register handshake
  assign grp_load = in_v_r && grp_free;
  assign in_stall = in_v_r && !grp_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (grp_load) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_data_byte;
      in_eob_r  <= in_end_of_buffer;
    end
  end

  // parser
  h3d_parse #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .en          (grp_load),
    .b           (in_byte_r),
    .eob         (in_eob_r),
    .grp         (grp)
  );

  // result sequencing
  h3d_outq u_outq (
    .clk               (clk),
    .rst_n             (rst_n),
    .grp_in            (grp),
    .grp_load          (grp_load),
    .grp_free          (grp_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_payload_byte  (out_payload_byte),
    .out_status        (out_status),
    .out_payload_count (out_payload_count),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire
